@@ design/pulse_interval_heart_rate_core_defines.svh @@
// Assertion macros shared by the heart-rate core.
`ifndef PULSE_INTERVAL_HEART_RATE_CORE_DEFINES_SVH
`define PULSE_INTERVAL_HEART_RATE_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define PIHR_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pihr assertion failed");

// next-cycle implication
`define PIHR_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pihr assertion failed");

`endif

@@ design/pihr_pkg.sv @@
package pihr_pkg;

	localparam int SAMPLE_W = 18;
	localparam int STAMP_W  = 32;
	localparam int CFG16_W  = 16;
	localparam int COUNT_W  = 4;
	localparam int SUM_W    = 20;
	localparam int RATE_W   = 16;
	localparam int DIVD_W   = 20;
	localparam int DIVS_W   = 16;
	localparam int STEP_W   = 4;

	localparam logic [DIVD_W-1:0] BPM_NUMERATOR = DIVD_W'(60000);

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_SAMPLE_FLOOR = 3'd0,
		REG_RISE_STEP    = 3'd1,
		REG_MIN_INTERVAL = 3'd2,
		REG_MAX_INTERVAL = 3'd3,
		REG_MIN_BPM      = 3'd4,
		REG_MAX_BPM      = 3'd5,
		REG_BEATS        = 3'd6
	} cfg_reg_t;

	typedef logic [STEP_W-1:0] step_t;

	// branch conditions of the sequencer
	typedef enum logic [3:0] {
		C_ALWAYS,
		C_NO_INPUT,
		C_ABOVE_FLOOR,
		C_NO_RISE,
		C_SKIP_BEAT,
		C_DIV_BUSY,
		C_BPM_OUT,
		C_NO_REPORT,
		C_OUT_FREE
	} cond_t;

	typedef enum logic [1:0] {
		DIV_NONE,
		DIV_BPM,
		DIV_AVG
	} div_sel_t;

	typedef struct packed {
		cond_t    cond;
		step_t    target;
		logic     zero_rate;
		logic     save_prev;
		logic     mark_beat;
		div_sel_t div_sel;
		logic     accum;
		logic     report;
		logic     emit;
	} uword_t;

	typedef struct packed {
		logic              start;
		logic [DIVD_W-1:0] dividend;
		logic [DIVS_W-1:0] divisor;
	} div_req_t;

	localparam step_t ST_WAIT   = 4'd0;
	localparam step_t ST_FLOOR  = 4'd1;
	localparam step_t ST_ZERO   = 4'd2;
	localparam step_t ST_RISE   = 4'd3;
	localparam step_t ST_BEAT   = 4'd4;
	localparam step_t ST_DWAIT1 = 4'd5;
	localparam step_t ST_BPMCHK = 4'd6;
	localparam step_t ST_ACCUM  = 4'd7;
	localparam step_t ST_CHKREP = 4'd8;
	localparam step_t ST_DWAIT2 = 4'd9;
	localparam step_t ST_REPORT = 4'd10;
	localparam step_t ST_EMIT   = 4'd11;
	localparam step_t ST_HOLD   = 4'd12;

	function automatic uword_t uword(cond_t c, step_t t);
		uword_t w;
		w = '0;
		w.cond = c;
		w.target = t;
		w.div_sel = DIV_NONE;
		return w;
	endfunction

	// control store: branch taken when the condition holds, else fall through
	function automatic uword_t ucode_rom(step_t s);
		uword_t w;
		w = uword(C_ALWAYS, ST_WAIT);
		unique case (s)
			ST_WAIT:   w = uword(C_NO_INPUT, ST_WAIT);
			ST_FLOOR:  w = uword(C_ABOVE_FLOOR, ST_RISE);
			ST_ZERO: begin
				w = uword(C_ALWAYS, ST_EMIT);
				w.zero_rate = 1'b1;
			end
			ST_RISE: begin
				w = uword(C_NO_RISE, ST_EMIT);
				w.save_prev = 1'b1;
			end
			ST_BEAT: begin
				w = uword(C_SKIP_BEAT, ST_EMIT);
				w.mark_beat = 1'b1;
				w.div_sel = DIV_BPM;
			end
			ST_DWAIT1: w = uword(C_DIV_BUSY, ST_DWAIT1);
			ST_BPMCHK: w = uword(C_BPM_OUT, ST_EMIT);
			ST_ACCUM: begin
				w = uword(C_ALWAYS, ST_CHKREP);
				w.accum = 1'b1;
			end
			ST_CHKREP: begin
				w = uword(C_NO_REPORT, ST_EMIT);
				w.div_sel = DIV_AVG;
			end
			ST_DWAIT2: w = uword(C_DIV_BUSY, ST_DWAIT2);
			ST_REPORT: begin
				w = uword(C_ALWAYS, ST_EMIT);
				w.report = 1'b1;
			end
			ST_EMIT: begin
				w = uword(C_OUT_FREE, ST_WAIT);
				w.emit = 1'b1;
			end
			ST_HOLD:   w = uword(C_ALWAYS, ST_EMIT);
			default:   w = uword(C_ALWAYS, ST_WAIT);
		endcase
		return w;
	endfunction

endpackage

@@ design/pihr_div.sv @@
module pihr_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  pihr_pkg::div_req_t               req,
	output logic                             busy,
	output logic [pihr_pkg::DIVD_W-1:0]      quotient
);
	import pihr_pkg::*;

	localparam int CNT_W = $clog2(DIVD_W);
	localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(DIVD_W - 1);

	logic [DIVD_W-1:0] quo_q;
	logic [DIVS_W-1:0] rem_q;
	logic [DIVS_W-1:0] dsr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;

	logic [DIVS_W:0] trial;
	logic [DIVS_W:0] diff;
	logic            ge;

	// restoring divide, one quotient bit per cycle, MSB first
	assign trial = {rem_q, quo_q[DIVD_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign ge    = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == LAST_BIT) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
			quo_q <= {quo_q[DIVD_W-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

@@ design/pulse_interval_heart_rate_core.sv @@
// Channel   Dir  Handshake              Payload
// s_*       in   s_tvalid / s_tready    tdata: ir_sample, time_ms
// m_*       out  m_tvalid / m_tready    tdata: pulse_rate; tuser: rate_valid, rate_updated
// cfg_*     in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One word at a time, run by a 13-step control store. A word below the floor, with no
// rise or with a rejected interval never waits on the divider; a beat that passes the
// interval check waits for a bpm divide on the serial divider, and one that completes
// an average waits for a second divide. Reset restores config defaults and clears all
// beat state. The result waits in an output register; the next word is taken meanwhile
// and stalls only at its own result step while m_tready is low.
`include "pulse_interval_heart_rate_core_defines.svh"

module pulse_interval_heart_rate_core #(
	parameter int TIME_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // [17:0] ir_sample, [49:18] time_ms, rest zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] pulse_rate
	output logic [1:0]  m_tuser,   // [0] rate_valid, [1] rate_updated
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [17:0] cfg_data
);
	import pihr_pkg::*;

	// configuration
	logic [SAMPLE_W-1:0] floor_q;
	logic [SAMPLE_W-1:0] rise_q;
	logic [CFG16_W-1:0]  min_int_q;
	logic [CFG16_W-1:0]  max_int_q;
	logic [CFG16_W-1:0]  min_bpm_q;
	logic [CFG16_W-1:0]  max_bpm_q;
	logic [COUNT_W-1:0]  bpr_q;

	// beat state
	logic [TIME_BITS-1:0] last_q;
	logic [SAMPLE_W-1:0]  prev_q;
	logic [SUM_W-1:0]     sum_q;
	logic [COUNT_W-1:0]   count_q;
	logic [RATE_W-1:0]    rate_q;
	logic                 valid_q;
	logic                 updated_q;

	// current word
	logic [SAMPLE_W-1:0]  sample_q;
	logic [TIME_BITS-1:0] now_q;

	// sequencer and output
	step_t             step_q;
	logic              m_tvalid_q;
	logic [RATE_W-1:0] m_rate_q;
	logic              m_valid_q;
	logic              m_updated_q;

	uword_t             uw;
	logic               cond_hit;
	logic               in_acc;
	logic               out_free;
	logic [TIME_BITS-1:0] interval;
	logic               int_ok;
	logic               rise;
	logic               bpm_out;
	logic               report_due;
	div_req_t           div_req;
	logic               div_busy;
	logic [DIVD_W-1:0]  div_quo;

	assign uw       = ucode_rom(step_q);
	assign s_tready = (step_q == ST_WAIT);
	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign cfg_ready = 1'b1;

	assign interval = now_q - last_q;
	assign int_ok   = (interval > TIME_BITS'(min_int_q)) && (interval < TIME_BITS'(max_int_q));
	assign rise     = (sample_q > prev_q) && ((sample_q - prev_q) > rise_q);
	assign bpm_out  = (div_quo < DIVD_W'(min_bpm_q)) || (div_quo > DIVD_W'(max_bpm_q));
	assign report_due = (count_q >= bpr_q) && (count_q != '0);

	always_comb begin
		unique case (uw.cond)
			C_ALWAYS:      cond_hit = 1'b1;
			C_NO_INPUT:    cond_hit = !s_tvalid;
			C_ABOVE_FLOOR: cond_hit = !(sample_q < floor_q);
			C_NO_RISE:     cond_hit = !rise;
			C_SKIP_BEAT:   cond_hit = (last_q == '0) || !int_ok;
			C_DIV_BUSY:    cond_hit = div_busy;
			C_BPM_OUT:     cond_hit = bpm_out;
			C_NO_REPORT:   cond_hit = !report_due;
			C_OUT_FREE:    cond_hit = out_free;
			default:       cond_hit = 1'b1;
		endcase
	end

	always_comb begin
		div_req = '0;
		unique case (uw.div_sel)
			DIV_BPM: begin
				div_req.start    = 1'b1;
				div_req.dividend = BPM_NUMERATOR;
				div_req.divisor  = interval[DIVS_W-1:0];
			end
			DIV_AVG: begin
				div_req.start    = 1'b1;
				div_req.dividend = sum_q;
				div_req.divisor  = DIVS_W'(count_q);
			end
			default: div_req = '0;
		endcase
	end

	pihr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_q   <= SAMPLE_W'(50000);
			rise_q    <= SAMPLE_W'(1000);
			min_int_q <= CFG16_W'(300);
			max_int_q <= CFG16_W'(2000);
			min_bpm_q <= CFG16_W'(40);
			max_bpm_q <= CFG16_W'(200);
			bpr_q     <= COUNT_W'(3);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SAMPLE_FLOOR: floor_q   <= cfg_data;
				REG_RISE_STEP:    rise_q    <= cfg_data;
				REG_MIN_INTERVAL: min_int_q <= cfg_data[CFG16_W-1:0];
				REG_MAX_INTERVAL: max_int_q <= cfg_data[CFG16_W-1:0];
				REG_MIN_BPM:      min_bpm_q <= cfg_data[CFG16_W-1:0];
				REG_MAX_BPM:      max_bpm_q <= cfg_data[CFG16_W-1:0];
				REG_BEATS:        bpr_q     <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			sample_q <= s_tdata[SAMPLE_W-1:0];
			now_q    <= TIME_BITS'(s_tdata[SAMPLE_W+STAMP_W-1:SAMPLE_W]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q    <= ST_WAIT;
			last_q    <= '0;
			prev_q    <= '0;
			sum_q     <= '0;
			count_q   <= '0;
			rate_q    <= '0;
			valid_q   <= 1'b0;
			updated_q <= 1'b0;
		end else begin
			step_q <= cond_hit ? uw.target : step_q + STEP_W'(1);
			if (in_acc) begin
				valid_q   <= 1'b0;
				updated_q <= 1'b0;
			end
			if (uw.zero_rate) begin
				rate_q    <= '0;
				updated_q <= 1'b1;
			end
			if (uw.save_prev) begin
				prev_q <= sample_q;
			end
			// the beat step is only reached after a qualifying rise
			if (uw.mark_beat) begin
				last_q <= now_q;
			end
			if (uw.accum) begin
				sum_q   <= sum_q + div_quo;
				count_q <= count_q + COUNT_W'(1);
			end
			if (uw.report) begin
				rate_q    <= div_quo[RATE_W-1:0];
				valid_q   <= 1'b1;
				updated_q <= 1'b1;
				sum_q     <= '0;
				count_q   <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (uw.emit && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (uw.emit && out_free) begin
			m_rate_q    <= rate_q;
			m_valid_q   <= valid_q;
			m_updated_q <= updated_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_rate_q;
	assign m_tuser  = {m_updated_q, m_valid_q};

	`PIHR_ASSERT_IMP(a_valid_implies_updated, m_tvalid && m_tuser[0], m_tuser[1])
	`PIHR_ASSERT_NXT(a_one_word_at_a_time, s_tvalid && s_tready, !s_tready)
	`PIHR_ASSERT_IMP(a_report_after_divide, step_q == ST_REPORT, !div_busy)
	`PIHR_ASSERT_IMP(a_empty_sum, count_q == '0, sum_q == '0)

endmodule
